// ----- hw/rtl/vcsp_pkg.sv -----
// Shared types and constants for the VOX chunk stream parser.
// No dependencies; used by vox_chunk_stream_parser_unit and vcsp_checker.
`default_nettype none

package vcsp_pkg;

  // Result kinds (travel on m_axis_tuser)
  localparam logic [2:0] KIND_VOXEL   = 3'd0;
  localparam logic [2:0] KIND_PALETTE = 3'd1;
  localparam logic [2:0] KIND_SIZE    = 3'd2;
  localparam logic [2:0] KIND_DONE    = 3'd3;
  localparam logic [2:0] KIND_FAILED  = 3'd4;

  // Error codes carried with KIND_FAILED
  localparam logic [2:0] ERR_MAGIC   = 3'd0;
  localparam logic [2:0] ERR_VERSION = 3'd1;
  localparam logic [2:0] ERR_MAIN    = 3'd2;
  localparam logic [2:0] ERR_CHUNK   = 3'd3;
  localparam logic [2:0] ERR_SIZE    = 3'd4;
  localparam logic [2:0] ERR_XCOUNT  = 3'd5;
  localparam logic [2:0] ERR_VOXEL   = 3'd6;
  localparam logic [2:0] ERR_RGBA    = 3'd7;

  // Four-character ids, first character in the low byte
  localparam logic [31:0] TAG_VOX  = 32'h2058_4F56;
  localparam logic [31:0] TAG_MAIN = 32'h4E49_414D;
  localparam logic [31:0] TAG_SIZE = 32'h455A_4953;
  localparam logic [31:0] TAG_XYZI = 32'h495A_5958;
  localparam logic [31:0] TAG_RGBA = 32'h4142_4752;

  localparam int PALETTE_WORDS_DEF = 256;
  localparam int POS_W = 34;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam int TDATA_OUT_W = 168;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] address;
    logic [31:0] value;
    logic [31:0] size_x;
    logic [31:0] size_y;
    logic [31:0] size_z;
    logic [2:0]  error_code;
    logic        last_in_run;
  } res_t;

  function automatic res_t mk_res(input logic [2:0] kind, input logic [31:0] address,
                                  input logic [31:0] value, input logic [31:0] size_x,
                                  input logic [31:0] size_y, input logic [31:0] size_z,
                                  input logic [2:0] error_code);
    res_t r;
    r.kind        = kind;
    r.address     = address;
    r.value       = value;
    r.size_x      = size_x;
    r.size_y      = size_y;
    r.size_z      = size_z;
    r.error_code  = error_code;
    r.last_in_run = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/vox_chunk_stream_parser_unit.sv -----
// Byte-serial VOX file parser: chunk walk, voxel/palette/size results.
// Depends on vcsp_pkg.
// Path: a byte transfer lands in the input register, is parsed into a 4-entry result
// queue once the queue has room, and shows on m_axis when it reaches the queue head.
// Throughput: one byte per cycle; a byte can yield two results, so the input stalls
// only when the result queue has fewer than two free slots.
// Reset (rst, synchronous): parser back to waiting for the magic, all counters and
// dimensions zero, input register and result queue empty.
`default_nettype none

module vox_chunk_stream_parser_unit #(
  parameter int PALETTE_WORDS = vcsp_pkg::PALETTE_WORDS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // byte stream in
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [7:0]                        s_axis_tdata,   // data_byte
  input  wire logic                              s_axis_tuser,   // first_of_file
  input  wire logic                              s_axis_tlast,   // last_of_file
  // result stream out
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // address[31:0], value[63:32], size_x[95:64], size_y[127:96], size_z[159:128],
  // error_code[162:160], zero pad[167:163]
  output logic [vcsp_pkg::TDATA_OUT_W-1:0]       m_axis_tdata,
  output logic [2:0]                             m_axis_tuser,   // kind
  output logic                                   m_axis_tlast    // last_in_run
);

  typedef enum logic [3:0] {
    PH_MAGIC, PH_VERSION, PH_MAINID, PH_MAINSIZES, PH_CHID, PH_CHSIZES,
    PH_SIZEBODY, PH_XCOUNT, PH_VOXEL, PH_RGBA, PH_SKIP, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {CK_OTHER, CK_SIZE, CK_XYZI, CK_RGBA} chunk_t;

  localparam logic [7:0] LAST_SLOT = 8'(PALETTE_WORDS - 1);

  // ---------------- input register ----------------
  logic       in_v;
  logic [7:0] in_byte;
  logic       in_first;
  logic       in_last;
  logic       proc;      // input register is parsed this cycle

  // ---------------- parser state ----------------
  phase_t                     phase;
  logic [3:0]                 cnt;          // bytes taken of the current field group
  chunk_t                     ckind;
  logic [31:0]                content_len;  // also the remaining skip count
  logic [31:0]                children_len;
  logic [31:0]                dim_x, dim_y, dim_z;
  logic [31:0]                plane_size;
  logic [31:0]                voxels_left;
  logic [31:0]                asm_word;
  logic [7:0]                 palette_slot;
  logic [vcsp_pkg::POS_W-1:0] byte_pos;
  logic [vcsp_pkg::POS_W-1:0] end_pos;

  phase_t                     phase_next;
  logic [3:0]                 cnt_next;
  chunk_t                     ckind_next;
  logic [31:0]                content_len_next, children_len_next;
  logic [31:0]                dim_x_next, dim_y_next, dim_z_next;
  logic [31:0]                plane_size_next, voxels_left_next, asm_word_next;
  logic [7:0]                 palette_slot_next;
  logic [vcsp_pkg::POS_W-1:0] byte_pos_next, end_pos_next;

  // state as seen by this byte (first_of_file restarts from reset values)
  phase_t                     cur_phase;
  logic [3:0]                 cur_cnt;
  chunk_t                     cur_ckind;
  logic [31:0]                cur_content, cur_children;
  logic [31:0]                cur_dx, cur_dy, cur_dz, cur_plane, cur_vleft, cur_asm;
  logic [7:0]                 cur_slot;
  logic [vcsp_pkg::POS_W-1:0] cur_pos, cur_end;

  always_comb begin
    if (in_first) begin
      cur_phase    = PH_MAGIC;
      cur_cnt      = '0;
      cur_ckind    = CK_OTHER;
      cur_content  = '0;
      cur_children = '0;
      cur_dx       = '0;
      cur_dy       = '0;
      cur_dz       = '0;
      cur_plane    = '0;
      cur_vleft    = '0;
      cur_asm      = '0;
      cur_slot     = '0;
      cur_pos      = '0;
      cur_end      = '0;
    end else begin
      cur_phase    = phase;
      cur_cnt      = cnt;
      cur_ckind    = ckind;
      cur_content  = content_len;
      cur_children = children_len;
      cur_dx       = dim_x;
      cur_dy       = dim_y;
      cur_dz       = dim_z;
      cur_plane    = plane_size;
      cur_vleft    = voxels_left;
      cur_asm      = asm_word;
      cur_slot     = palette_slot;
      cur_pos      = byte_pos;
      cur_end      = end_pos;
    end
  end

  // field assembly and voxel address
  logic [31:0] aw;          // assembly word after taking this byte
  logic [3:0]  cnt1;
  logic [31:0] vox_addr;
  logic [31:0] vleft_dec;

  assign aw        = cur_asm | ({24'd0, in_byte} << {cur_cnt[1:0], 3'b000});
  assign cnt1      = cur_cnt + 4'd1;
  assign vox_addr  = ({24'd0, aw[23:16]} * cur_plane) + ({24'd0, aw[15:8]} * cur_dx)
                     + {24'd0, aw[7:0]};
  assign vleft_dec = cur_vleft - 32'd1;

  // Up to three candidate results per byte in order: a write/report/fail from the
  // phase itself, finished at a chunk boundary, and the end-of-file outcome.
  // At most two of them are ever present together.
  vcsp_pkg::res_t ra, rb, rc;
  logic           ra_v, rb_v, rc_v;
  logic           skip_req;
  logic [31:0]    skip_len;
  logic           bnd;

  always_comb begin
    phase_next        = cur_phase;
    cnt_next          = cur_cnt;
    ckind_next        = cur_ckind;
    content_len_next  = cur_content;
    children_len_next = cur_children;
    dim_x_next        = cur_dx;
    dim_y_next        = cur_dy;
    dim_z_next        = cur_dz;
    plane_size_next   = cur_plane;
    voxels_left_next  = cur_vleft;
    asm_word_next     = cur_asm;
    palette_slot_next = cur_slot;
    byte_pos_next     = cur_pos;
    end_pos_next      = cur_end;
    ra   = vcsp_pkg::mk_res(vcsp_pkg::KIND_DONE, '0, '0, '0, '0, '0, '0);
    rb   = vcsp_pkg::mk_res(vcsp_pkg::KIND_DONE, '0, '0, '0, '0, '0, '0);
    rc   = vcsp_pkg::mk_res(vcsp_pkg::KIND_DONE, '0, '0, '0, '0, '0, '0);
    ra_v = 1'b0;
    rb_v = 1'b0;
    rc_v = 1'b0;
    skip_req = 1'b0;
    skip_len = '0;
    bnd      = 1'b0;

    if (cur_phase != PH_DONE) begin
      if (cur_pos != vcsp_pkg::POS_MAX) byte_pos_next = cur_pos + 1'b1;
      asm_word_next = aw;
      cnt_next      = cnt1;

      unique case (cur_phase)
        PH_MAGIC, PH_VERSION, PH_MAINID: begin
          if (cnt1 == 4'd4) begin
            asm_word_next = '0;
            cnt_next      = '0;
            if (cur_phase == PH_VERSION) begin
              phase_next = PH_MAINID;
            end else if (cur_phase == PH_MAGIC) begin
              if (aw != vcsp_pkg::TAG_VOX) begin
                phase_next = PH_DONE;
                ra_v = 1'b1;
                ra   = vcsp_pkg::mk_res(vcsp_pkg::KIND_FAILED, '0, '0, '0, '0, '0,
                                        vcsp_pkg::ERR_MAGIC);
              end else begin
                phase_next = PH_VERSION;
              end
            end else begin
              if (aw != vcsp_pkg::TAG_MAIN) begin
                phase_next = PH_DONE;
                ra_v = 1'b1;
                ra   = vcsp_pkg::mk_res(vcsp_pkg::KIND_FAILED, '0, '0, '0, '0, '0,
                                        vcsp_pkg::ERR_MAIN);
              end else begin
                phase_next = PH_MAINSIZES;
              end
            end
          end
        end
        PH_MAINSIZES, PH_CHSIZES: begin
          if (cnt1 == 4'd4) begin
            content_len_next = aw;
            asm_word_next    = '0;
          end else if (cnt1 == 4'd8) begin
            children_len_next = aw;
            if (cur_phase == PH_MAINSIZES) begin
              end_pos_next = byte_pos_next + {2'b00, cur_content} + {2'b00, aw};
              skip_req = 1'b1;
              skip_len = cur_content;
            end else begin
              asm_word_next = '0;
              cnt_next      = '0;
              unique case (cur_ckind)
                CK_SIZE:  phase_next = PH_SIZEBODY;
                CK_XYZI:  phase_next = PH_XCOUNT;
                CK_RGBA: begin
                  phase_next        = PH_RGBA;
                  palette_slot_next = '0;
                end
                CK_OTHER: begin
                  skip_req = 1'b1;
                  skip_len = cur_content + aw;
                end
              endcase
            end
          end
        end
        PH_CHID: begin
          if (cnt1 == 4'd4) begin
            priority if (aw == vcsp_pkg::TAG_SIZE) ckind_next = CK_SIZE;
            else if (aw == vcsp_pkg::TAG_XYZI)     ckind_next = CK_XYZI;
            else if (aw == vcsp_pkg::TAG_RGBA)     ckind_next = CK_RGBA;
            else                                   ckind_next = CK_OTHER;
            phase_next    = PH_CHSIZES;
            asm_word_next = '0;
            cnt_next      = '0;
          end
        end
        PH_SIZEBODY: begin
          if (cnt1 == 4'd4) begin
            dim_x_next    = aw;
            asm_word_next = '0;
          end else if (cnt1 == 4'd8) begin
            dim_y_next    = aw;
            asm_word_next = '0;
          end else if (cnt1 == 4'd12) begin
            dim_z_next      = aw;
            plane_size_next = cur_dy * cur_dx;
            ra_v = 1'b1;
            ra   = vcsp_pkg::mk_res(vcsp_pkg::KIND_SIZE, '0, '0, cur_dx, cur_dy, aw, '0);
            skip_req = 1'b1;
            // negative padding counts as none
            skip_len = (cur_content >= 32'd12) ? (cur_content - 32'd12) : 32'd0;
          end
        end
        PH_XCOUNT: begin
          if (cnt1 == 4'd4) begin
            voxels_left_next = aw;
            asm_word_next    = '0;
            cnt_next         = '0;
            if (aw == 32'd0) bnd = 1'b1;
            else             phase_next = PH_VOXEL;
          end
        end
        PH_VOXEL: begin
          if (cnt1 == 4'd4) begin
            ra_v = 1'b1;
            ra   = vcsp_pkg::mk_res(vcsp_pkg::KIND_VOXEL, vox_addr,
                                    {24'd0, aw[31:24] - 8'd1}, '0, '0, '0, '0);
            voxels_left_next = vleft_dec;
            asm_word_next    = '0;
            cnt_next         = '0;
            if (vleft_dec == 32'd0) bnd = 1'b1;
          end
        end
        PH_RGBA: begin
          if (cnt1[1:0] == 2'd0) begin
            ra_v = 1'b1;
            ra   = vcsp_pkg::mk_res(vcsp_pkg::KIND_PALETTE, {24'd0, cur_slot}, aw,
                                    '0, '0, '0, '0);
            palette_slot_next = cur_slot + 8'd1;
            asm_word_next     = '0;
            cnt_next          = '0;
            if (cur_slot == LAST_SLOT) bnd = 1'b1;
          end
        end
        PH_SKIP: begin
          asm_word_next    = '0;
          cnt_next         = '0;
          content_len_next = cur_content - 32'd1;
          if (cur_content == 32'd1) bnd = 1'b1;
        end
        PH_DONE: begin
        end
        default: phase_next = PH_DONE;
      endcase

      if (skip_req) begin
        asm_word_next = '0;
        cnt_next      = '0;
        if (skip_len == 32'd0) begin
          bnd = 1'b1;
        end else begin
          content_len_next = skip_len;
          phase_next       = PH_SKIP;
        end
      end

      // chunk boundary: finished once the MAIN end position is reached
      if (bnd) begin
        asm_word_next = '0;
        cnt_next      = '0;
        if (byte_pos_next >= end_pos_next) begin
          phase_next = PH_DONE;
          rb_v = 1'b1;
        end else begin
          phase_next = PH_CHID;
        end
      end

      // end of file: failure code by field being read, else a clean finish
      if (in_last && phase_next != PH_DONE) begin
        rc_v = 1'b1;
        unique case (phase_next)
          PH_MAGIC:    rc.error_code = vcsp_pkg::ERR_MAGIC;
          PH_VERSION:  rc.error_code = vcsp_pkg::ERR_VERSION;
          PH_MAINID,
          PH_MAINSIZES: rc.error_code = vcsp_pkg::ERR_MAIN;
          PH_CHSIZES:  rc.error_code = vcsp_pkg::ERR_CHUNK;
          PH_SIZEBODY: rc.error_code = vcsp_pkg::ERR_SIZE;
          PH_XCOUNT:   rc.error_code = vcsp_pkg::ERR_XCOUNT;
          PH_VOXEL:    rc.error_code = vcsp_pkg::ERR_VOXEL;
          PH_RGBA:     rc.error_code = vcsp_pkg::ERR_RGBA;
          default:     rc.error_code = '0;
        endcase
        if (phase_next == PH_CHID || phase_next == PH_SKIP) rc.kind = vcsp_pkg::KIND_DONE;
        else                                                rc.kind = vcsp_pkg::KIND_FAILED;
        phase_next = PH_DONE;
      end
    end
  end

  // compact candidates into at most two queue entries; mark the final one
  vcsp_pkg::res_t e0, e1;
  logic [1:0]     n_res;

  always_comb begin
    e0    = ra;
    e1    = rb;
    n_res = 2'd0;
    if (ra_v) begin
      e0    = ra;
      n_res = 2'd1;
      if (rb_v) begin
        e1    = rb;
        n_res = 2'd2;
      end else if (rc_v) begin
        e1    = rc;
        n_res = 2'd2;
      end
    end else if (rb_v) begin
      e0    = rb;
      n_res = 2'd1;
      if (rc_v) begin
        e1    = rc;
        n_res = 2'd2;
      end
    end else if (rc_v) begin
      e0    = rc;
      n_res = 2'd1;
    end
    if (n_res == 2'd2) e1.last_in_run = 1'b1;
    else               e0.last_in_run = 1'b1;
  end

  // ---------------- result queue ----------------
  vcsp_pkg::res_t q [4];
  logic [1:0]     wp, rp;
  logic [2:0]     qcnt;
  logic           pop;
  logic [1:0]     push_n;

  assign proc          = in_v && (qcnt <= 3'd2);
  assign s_axis_tready = !in_v || proc;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign push_n        = proc ? n_res : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_v <= 1'b1;
    end else if (proc) begin
      in_v <= 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte  <= s_axis_tdata;
      in_first <= s_axis_tuser;
      in_last  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_MAGIC;
      cnt          <= '0;
      ckind        <= CK_OTHER;
      content_len  <= '0;
      children_len <= '0;
      dim_x        <= '0;
      dim_y        <= '0;
      dim_z        <= '0;
      plane_size   <= '0;
      voxels_left  <= '0;
      asm_word     <= '0;
      palette_slot <= '0;
      byte_pos     <= '0;
      end_pos      <= '0;
    end else if (proc) begin
      phase        <= phase_next;
      cnt          <= cnt_next;
      ckind        <= ckind_next;
      content_len  <= content_len_next;
      children_len <= children_len_next;
      dim_x        <= dim_x_next;
      dim_y        <= dim_y_next;
      dim_z        <= dim_z_next;
      plane_size   <= plane_size_next;
      voxels_left  <= voxels_left_next;
      asm_word     <= asm_word_next;
      palette_slot <= palette_slot_next;
      byte_pos     <= byte_pos_next;
      end_pos      <= end_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      qcnt <= '0;
    end else begin
      wp   <= wp + push_n;
      rp   <= rp + {1'b0, pop};
      qcnt <= qcnt + {1'b0, push_n} - {2'b00, pop};
    end
    if (push_n != 2'd0) q[wp]        <= e0;
    if (push_n == 2'd2) q[wp + 2'd1] <= e1;
  end

  assign m_axis_tvalid = (qcnt != 3'd0);
  assign m_axis_tuser  = q[rp].kind;
  assign m_axis_tlast  = q[rp].last_in_run;
  assign m_axis_tdata  = {5'd0, q[rp].error_code, q[rp].size_z, q[rp].size_y,
                          q[rp].size_x, q[rp].value, q[rp].address};

endmodule

`default_nettype wire

// ----- hw/rtl/vcsp_checker.sv -----
// Port-level checks for vox_chunk_stream_parser_unit, bound into each instance of it.
// Depends on vcsp_pkg.
`default_nettype none

module vcsp_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_axis_tvalid,
  input wire logic                        s_axis_tready,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [vcsp_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  input wire logic [2:0]                  m_axis_tuser,
  input wire logic                        m_axis_tlast
);

  // nothing is offered on the result side the cycle after reset
  a_empty_after_reset: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result offered right after reset");

  // a stalled result transfer keeps its content
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // error code only accompanies a failure
  a_err_only_failed: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != vcsp_pkg::KIND_FAILED |-> m_axis_tdata[162:160] == 3'd0)
    else $error("error code on non-failure result");

  // finish and failure always close a run
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == vcsp_pkg::KIND_DONE
      || m_axis_tuser == vcsp_pkg::KIND_FAILED) |-> m_axis_tlast)
    else $error("finish or failure not last of its run");

  // palette word index stays within a byte
  a_palette_addr: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == vcsp_pkg::KIND_PALETTE |-> m_axis_tdata[31:8] == 24'd0)
    else $error("palette index out of range");

endmodule

bind vox_chunk_stream_parser_unit vcsp_checker u_vcsp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
